>>> rtl/core/tlss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricubic level-set sampler package
// Shared widths, fixed-point constants and the queue item type.
// ----------------------------------------------------------------------------
package tlss_pkg;

  // Grid size default and queue depth.
  localparam int GRID_DIM_DEFAULT = 32;
  localparam int QUEUE_DEPTH      = 4;

  // Field widths.
  localparam int CELL_W    = 5;
  localparam int SAMPLE_W  = 16;
  localparam int POINT_W   = 15;
  localparam int FRAC_BITS = 10;
  localparam int INT_BITS  = POINT_W - FRAC_BITS;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  // Datapath widths: kernel values, weight numerators, accumulator.
  localparam int VAL_W  = 20;
  localparam int WGT_W  = 36;
  localparam int WLO_W  = 17;
  localparam int ACC_W  = 56;
  localparam int T_W    = ACC_W - 30;
  localparam int U_W    = 28;
  localparam int RCP_W  = 27;
  localparam int PROD_W = U_W + RCP_W;

  // Weight denominator 6 * 2^30 and half of it for rounding.
  localparam logic signed [WGT_W-1:0] W_DEN      = 36'sd6442450944;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 56'sd3221225472;
  // Offset 6 * 2^24 keeps the quotient input positive; reciprocal of 6 at 2^29.
  localparam logic signed [U_W-1:0]   U_OFFSET   = 28'sd100663296;
  localparam logic signed [U_W-1:0]   Q_OFFSET   = 28'sd16777216;
  localparam logic [RCP_W-1:0]        RECIP6     = 27'd89478485;
  localparam int                      RCP_SHIFT  = 29;

  // Item kind carried from the front to the back.
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_EVAL  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CELL_W-1:0]   cell_x;
    logic [CELL_W-1:0]   cell_y;
    logic [CELL_W-1:0]   cell_z;
    logic [SAMPLE_W-1:0] sample;
    logic [POINT_W-1:0]  point_x;
    logic [POINT_W-1:0]  point_y;
    logic [POINT_W-1:0]  point_z;
  } item_t;

endpackage

>>> rtl/core/tlss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler front end
// Accepts input beats, drops writes that fall outside the grid, and queues
// the remaining items for the back end.
// ----------------------------------------------------------------------------
module tlss_front #(
  parameter int GRID_DIM = tlss_pkg::GRID_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tlss_pkg::item_t                  in_item,
  output logic                             q_valid,
  input  logic                             q_ready,
  output tlss_pkg::item_t                  q_item
);

  localparam int PTR_W = $clog2(tlss_pkg::QUEUE_DEPTH);

  tlss_pkg::item_t    slots [tlss_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W:0]     count;
  logic               in_grid;
  logic               push;
  logic               pop;

  // A write is kept only when its cell lies inside the grid.
  assign in_grid = (int'(in_item.cell_x) < GRID_DIM) && (int'(in_item.cell_y) < GRID_DIM) &&
                   (int'(in_item.cell_z) < GRID_DIM);
  assign in_ready = (count != (PTR_W+1)'(tlss_pkg::QUEUE_DEPTH));
  assign push = in_valid && in_ready &&
                ((in_item.kind == tlss_pkg::KIND_EVAL) || in_grid);
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_item = slots[head];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= in_item;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tlss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler back end
// Holds the sample grid, builds the kernel weights and runs all 21 cubic
// kernels through one multiply-accumulate pipeline with a divide-by-6 tail.
// ----------------------------------------------------------------------------
module tlss_back #(
  parameter int GRID_DIM = tlss_pkg::GRID_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  tlss_pkg::item_t                      q_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tlss_pkg::OUT_TDATA_W-1:0] out_value
);

  localparam int AW    = $clog2(GRID_DIM * GRID_DIM * GRID_DIM);
  localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int VW    = tlss_pkg::VAL_W;
  localparam int WW    = tlss_pkg::WGT_W;
  localparam int LW    = tlss_pkg::WLO_W;
  localparam int HW    = WW - LW;
  localparam int AC    = tlss_pkg::ACC_W;
  localparam int FB    = tlss_pkg::FRAC_BITS;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_WGT    = 8'b0000_0010,
    ST_TAPX   = 8'b0000_0100,
    ST_DRAINX = 8'b0000_1000,
    ST_TAPY   = 8'b0001_0000,
    ST_DRAINY = 8'b0010_0000,
    ST_TAPZ   = 8'b0100_0000,
    ST_DRAINZ = 8'b1000_0000
  } state_t;

  state_t state;

  // Grid memory.
  logic [tlss_pkg::SAMPLE_W-1:0] grid_mem [DEPTH];
  logic [tlss_pkg::SAMPLE_W-1:0] mem_q;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic                          mem_we;

  // Query point held for the evaluation.
  logic [tlss_pkg::POINT_W-1:0] pt_x;
  logic [tlss_pkg::POINT_W-1:0] pt_y;
  logic [tlss_pkg::POINT_W-1:0] pt_z;

  // Weight generation.
  logic [1:0]               axis;
  logic [1:0]               step;
  logic [FB-1:0]            frac;
  logic [2*FB-1:0]          f2;
  logic [3*FB-1:0]          f3;
  logic signed [WW-1:0]     wgt [3][4];
  logic signed [WW-1:0]     w_new [4];

  // Tap sequencing.
  logic [5:0]               n;
  logic signed [VW-1:0]     res [16];
  logic                     oob;

  // Pipeline stage 1: operand fetch.
  logic                     v1;
  logic                     src_mem1;
  logic                     zero1;
  logic signed [VW-1:0]     res_q;
  logic signed [WW-1:0]     w1;
  logic                     first1, last1, fin1;
  logic [3:0]               dest1;
  // Stage 2: partial products.
  logic                     v2;
  logic signed [HW+VW-1:0]  ph;
  logic signed [LW+VW:0]    pl;
  logic                     first2, last2, fin2;
  logic [3:0]               dest2;
  logic signed [VW-1:0]     p_op;
  // Stage 3: accumulator.
  logic                     v3;
  logic signed [AC-1:0]     acc;
  logic signed [AC-1:0]     acc_next;
  logic                     fin3;
  logic [3:0]               dest3;
  // Stage 4: offset quotient input.
  logic                     v4;
  logic [tlss_pkg::U_W-1:0] u4;
  logic                     fin4;
  logic [3:0]               dest4;
  logic signed [tlss_pkg::T_W-1:0] t_q;
  logic signed [tlss_pkg::U_W-1:0] u_s;
  // Stage 5: reciprocal product.
  logic                     v5;
  logic [tlss_pkg::PROD_W-1:0] prod5;
  logic [tlss_pkg::U_W-1:0] u5;
  logic                     fin5;
  logic [3:0]               dest5;
  logic [tlss_pkg::T_W-1:0] q0;
  logic [tlss_pkg::U_W-1:0] rem;
  logic signed [tlss_pkg::U_W-1:0] q_s;
  logic signed [VW-1:0]     kres;
  logic                     busy;

  // Flattened grid address of a cell.
  function automatic logic [AW-1:0] grid_addr(input int x, input int y, input int z);
    return AW'((z * GRID_DIM + y) * GRID_DIM + x);
  endfunction

  assign busy = v1 | v2 | v3 | v4 | v5;

  // The back end takes writes whenever it is idle and an evaluation only
  // when it is idle and the result register is free.
  assign q_ready = (state == ST_IDLE) &&
                   ((q_item.kind == tlss_pkg::KIND_WRITE) || !out_valid);
  assign mem_we  = q_valid && q_ready && (q_item.kind == tlss_pkg::KIND_WRITE);
  assign wr_addr = grid_addr(int'(q_item.cell_x), int'(q_item.cell_y), int'(q_item.cell_z));

  // Neighbor coordinates for the current x tap.
  always_comb begin
    int cx, cy, cz;
    cx = int'(pt_x[tlss_pkg::POINT_W-1:FB]) - 1 + int'(n[1:0]);
    cy = int'(pt_y[tlss_pkg::POINT_W-1:FB]) - 1 + int'(n[3:2]);
    cz = int'(pt_z[tlss_pkg::POINT_W-1:FB]) - 1 + int'(n[5:4]);
    oob = (cx < 0) || (cy < 0) || (cz < 0) ||
          (cx >= GRID_DIM) || (cy >= GRID_DIM) || (cz >= GRID_DIM);
    rd_addr = oob ? '0 : grid_addr(cx, cy, cz);
  end

  // Grid memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[wr_addr] <= q_item.sample;
    end
    mem_q <= grid_mem[rd_addr];
  end

  // Fraction of the axis whose weights are being built.
  always_comb begin
    case (axis)
      2'd0:    frac = pt_x[FB-1:0];
      2'd1:    frac = pt_y[FB-1:0];
      default: frac = pt_z[FB-1:0];
    endcase
  end

  // Weight numerators over 6 * 2^30 from f, f^2 and f^3.
  always_comb begin
    logic signed [WW-1:0] t1, t2, t3;
    t1 = $signed(WW'(frac)) <<< 20;
    t2 = $signed(WW'(f2)) <<< 10;
    t3 = $signed(WW'(f3));
    w_new[0] = -(t1 <<< 1) + (t2 <<< 1) + t2 - t3;
    w_new[1] = tlss_pkg::W_DEN - (t2 <<< 2) - (t2 <<< 1) + (t3 <<< 1) + t3
               - (t1 <<< 1) - t1;
    w_new[2] = (t1 <<< 2) + (t1 <<< 1) + (t2 <<< 1) + t2 - (t3 <<< 1) - t3;
    w_new[3] = t3 - t1;
  end

  // Sequencer and operand fetch.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= '0;
      step  <= '0;
      n     <= '0;
      v1    <= 1'b0;
    end else begin
      v1 <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_ready && (q_item.kind == tlss_pkg::KIND_EVAL)) begin
            pt_x  <= q_item.point_x;
            pt_y  <= q_item.point_y;
            pt_z  <= q_item.point_z;
            axis  <= '0;
            step  <= '0;
            state <= ST_WGT;
          end
        end
        ST_WGT: begin
          if (step == 2'd0) begin
            f2   <= (2*FB)'(frac) * (2*FB)'(frac);
            step <= 2'd1;
          end else if (step == 2'd1) begin
            f3   <= (3*FB)'(f2) * (3*FB)'(frac);
            step <= 2'd2;
          end else begin
            for (int i = 0; i < 4; i++) begin
              wgt[axis][i] <= w_new[i];
            end
            step <= 2'd0;
            if (axis == 2'd2) begin
              n     <= '0;
              state <= ST_TAPX;
            end else begin
              axis <= axis + 1'b1;
            end
          end
        end
        ST_TAPX: begin
          v1       <= 1'b1;
          src_mem1 <= 1'b1;
          zero1    <= oob;
          w1       <= wgt[0][n[1:0]];
          first1   <= (n[1:0] == 2'd0);
          last1    <= (n[1:0] == 2'd3);
          fin1     <= 1'b0;
          dest1    <= n[5:2];
          n        <= n + 1'b1;
          if (n == 6'd63) begin
            state <= ST_DRAINX;
          end
        end
        ST_DRAINX: begin
          if (!busy) begin
            n     <= '0;
            state <= ST_TAPY;
          end
        end
        ST_TAPY: begin
          v1       <= 1'b1;
          src_mem1 <= 1'b0;
          zero1    <= 1'b0;
          res_q    <= res[n[3:0]];
          w1       <= wgt[1][n[1:0]];
          first1   <= (n[1:0] == 2'd0);
          last1    <= (n[1:0] == 2'd3);
          fin1     <= 1'b0;
          dest1    <= {2'b00, n[3:2]};
          n        <= n + 1'b1;
          if (n[3:0] == 4'd15) begin
            state <= ST_DRAINY;
          end
        end
        ST_DRAINY: begin
          if (!busy) begin
            n     <= '0;
            state <= ST_TAPZ;
          end
        end
        ST_TAPZ: begin
          v1       <= 1'b1;
          src_mem1 <= 1'b0;
          zero1    <= 1'b0;
          res_q    <= res[{2'b00, n[1:0]}];
          w1       <= wgt[2][n[1:0]];
          first1   <= (n[1:0] == 2'd0);
          last1    <= (n[1:0] == 2'd3);
          fin1     <= 1'b1;
          dest1    <= '0;
          n        <= n + 1'b1;
          if (n[1:0] == 2'd3) begin
            state <= ST_DRAINZ;
          end
        end
        ST_DRAINZ: begin
          if (!busy) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Stage 2: split the weight into high and low halves and multiply.
  assign p_op = src_mem1 ? (zero1 ? '0 : VW'($signed(mem_q))) : res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ph     <= $signed(w1[WW-1:LW]) * p_op;
    pl     <= $signed({1'b0, w1[LW-1:0]}) * p_op;
    first2 <= first1;
    last2  <= last1;
    fin2   <= fin1;
    dest2  <= dest1;
  end

  // Stage 3: accumulate four taps of a kernel.
  assign acc_next = (first2 ? '0 : acc) + (AC'(ph) <<< LW) + AC'(pl);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2 && last2;
    end
    if (v2) begin
      acc <= acc_next;
    end
    fin3  <= fin2;
    dest3 <= dest2;
  end

  // Stage 4: round, drop 2^30 and offset for the divide by six.
  assign t_q = tlss_pkg::T_W'((acc + tlss_pkg::ROUND_HALF) >>> 30);
  assign u_s = tlss_pkg::U_W'(t_q) + tlss_pkg::U_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    u4    <= u_s;
    fin4  <= fin3;
    dest4 <= dest3;
  end

  // Stage 5: multiply by the reciprocal of six.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    prod5 <= tlss_pkg::PROD_W'(u4) * tlss_pkg::PROD_W'(tlss_pkg::RECIP6);
    u5    <= u4;
    fin5  <= fin4;
    dest5 <= dest4;
  end

  // Correct the estimate by one and remove the offset.
  always_comb begin
    q0   = prod5[tlss_pkg::RCP_SHIFT +: tlss_pkg::T_W];
    rem  = u5 - (tlss_pkg::U_W'(q0) << 2) - (tlss_pkg::U_W'(q0) << 1);
    q_s  = $signed(tlss_pkg::U_W'(q0)) + $signed(tlss_pkg::U_W'(rem >= 6))
           - tlss_pkg::Q_OFFSET;
    kres = q_s[VW-1:0];
  end

  // Kernel results feed later kernels or the result register.
  always_ff @(posedge clk) begin
    if (v5 && !fin5) begin
      res[dest5] <= kres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (v5 && fin5) begin
        out_valid <= 1'b1;
      end
    end
    if (v5 && fin5) begin
      out_value <= tlss_pkg::OUT_TDATA_W'(kres);
    end
  end

endmodule

>>> rtl/core/tricubic_level_set_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricubic level-set sampler
// Stores a cubic grid of Q8.8 samples and interpolates it at Q5.10 points.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis. tuser selects the kind: 0 writes one grid
//   sample at cell_x/y/z, 1 evaluates the field at point_x/y/z. Writes whose
//   cell lies outside the grid are dropped. Every evaluate beat yields one
//   m_axis beat with the Q16.8 value in tdata and the inside flag in tuser.
//   A four-entry queue sits between the input and the compute engine, so
//   input beats keep being taken while a result waits.
//   A write passes through the queue to the grid memory. An evaluate runs
//   weight setup for each axis, 64 grid reads through the single memory
//   read port, 16 and 4 taps for the y and z passes, and three drains of
//   the 5-stage multiply-accumulate and divide pipeline.
//   The next evaluation starts only after the previous result beat is taken.
//   Reset clears the queue and control state; grid contents are undefined
//   until written, so load every sample before evaluating.
//   A stalled m_axis holds its beat; writes at the queue head still drain.
// ----------------------------------------------------------------------------
module tricubic_level_set_sampler_unit #(
  parameter int GRID_DIM = tlss_pkg::GRID_DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cell_x[4:0], cell_y[9:5], cell_z[14:10], sample_value[30:15],
  // point_x[45:31], point_y[60:46], point_z[75:61], zero fill
  input  logic [tlss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // op
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // field_value[23:0]
  output logic [tlss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // is_inside
  output logic                                m_axis_tuser
);

  tlss_pkg::item_t in_item;
  tlss_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;
  logic signed [tlss_pkg::OUT_TDATA_W-1:0] value;

  // Unpack the input beat.
  always_comb begin
    in_item.kind    = tlss_pkg::kind_t'(s_axis_tuser);
    in_item.cell_x  = s_axis_tdata[4:0];
    in_item.cell_y  = s_axis_tdata[9:5];
    in_item.cell_z  = s_axis_tdata[14:10];
    in_item.sample  = s_axis_tdata[30:15];
    in_item.point_x = s_axis_tdata[45:31];
    in_item.point_y = s_axis_tdata[60:46];
    in_item.point_z = s_axis_tdata[75:61];
  end

  tlss_front #(
    .GRID_DIM (GRID_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  tlss_back #(
    .GRID_DIM (GRID_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (value)
  );

  // Result beat: value and its sign as the inside flag.
  assign m_axis_tdata = value;
  assign m_axis_tuser = value[tlss_pkg::OUT_TDATA_W-1];

endmodule

>>> tb/tricubic_level_set_sampler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricubic level-set sampler testbench
// Loads grid regions near the corners, then sends directed and random
// writes and evaluations. A behavioral interpolator predicts every result
// beat, and the monitor compares each one field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tricubic_level_set_sampler_unit_tb;

  localparam int     DIM       = 32;
  localparam longint DEN       = longint'(6) << 30;
  localparam int     CYCLE_CAP = 2000000;

  typedef struct {
    tlss_pkg::kind_t                      kind;
    logic [tlss_pkg::CELL_W-1:0]          cx, cy, cz;
    logic signed [tlss_pkg::SAMPLE_W-1:0] sample;
    logic [tlss_pkg::POINT_W-1:0]         px, py, pz;
  } beat_t;

  typedef struct {
    logic [23:0] value;
    logic        is_inside;
  } field_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [tlss_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tlss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  beat_t  pending_beats[$];
  field_t expected_fields[$];
  beat_t  beat_on_bus;
  logic signed [15:0] grid_model [DIM*DIM*DIM];
  bit     cell_loaded [DIM*DIM*DIM];
  int     cycle_count = 0;
  int     error_count = 0;

  tricubic_level_set_sampler_unit #(.GRID_DIM(DIM)) dut (.*);

  always #2 clk = ~clk;

  // Weight numerators over 6 * 2^30 for a fraction of f/1024.
  function automatic void cubic_weights(input longint f, output longint w[4]);
    longint f2, f3;
    f2 = f * f;
    f3 = f2 * f;
    w[0] = -2 * (f << 20) + 3 * (f2 << 10) - f3;
    w[1] = DEN - 6 * (f2 << 10) + 3 * f3 - 3 * (f << 20);
    w[2] = 6 * (f << 20) + 3 * (f2 << 10) - 3 * f3;
    w[3] = f3 - (f << 20);
  endfunction

  // One kernel tap sum, divided by the denominator, rounded half up.
  function automatic longint cubic_tap(input longint p[4], input longint w[4]);
    longint num, q;
    num = w[0] * p[0] + w[1] * p[1] + w[2] * p[2] + w[3] * p[3] + DEN / 2;
    q = num / DEN;
    if ((num % DEN) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint grid_at(input int x, input int y, input int z);
    if (x < 0 || y < 0 || z < 0 || x >= DIM || y >= DIM || z >= DIM) return 0;
    return longint'(grid_model[(z * DIM + y) * DIM + x]);
  endfunction

  // True when every in-grid neighbor of the point has been written.
  function automatic bit neighbors_loaded(input logic [tlss_pkg::POINT_W-1:0] px,
                                          input logic [tlss_pkg::POINT_W-1:0] py,
                                          input logic [tlss_pkg::POINT_W-1:0] pz);
    int gx, gy, gz, x, y, z;
    gx = px >> tlss_pkg::FRAC_BITS;
    gy = py >> tlss_pkg::FRAC_BITS;
    gz = pz >> tlss_pkg::FRAC_BITS;
    for (z = gz - 1; z <= gz + 2; z++)
      for (y = gy - 1; y <= gy + 2; y++)
        for (x = gx - 1; x <= gx + 2; x++)
          if (x >= 0 && y >= 0 && z >= 0 && x < DIM && y < DIM && z < DIM)
            if (!cell_loaded[(z * DIM + y) * DIM + x]) return 1'b0;
    return 1'b1;
  endfunction

  // Separable interpolation along x, then y, then z, with saturation.
  function automatic field_t interpolate_field(input beat_t b);
    longint wx[4], wy[4], wz[4], row[4], col[4], plane[4], v;
    int gx, gy, gz, i, j, k;
    field_t r;
    gx = b.px >> tlss_pkg::FRAC_BITS;
    gy = b.py >> tlss_pkg::FRAC_BITS;
    gz = b.pz >> tlss_pkg::FRAC_BITS;
    cubic_weights(longint'(b.px[tlss_pkg::FRAC_BITS-1:0]), wx);
    cubic_weights(longint'(b.py[tlss_pkg::FRAC_BITS-1:0]), wy);
    cubic_weights(longint'(b.pz[tlss_pkg::FRAC_BITS-1:0]), wz);
    for (k = 0; k < 4; k++) begin
      for (j = 0; j < 4; j++) begin
        for (i = 0; i < 4; i++) row[i] = grid_at(gx - 1 + i, gy - 1 + j, gz - 1 + k);
        col[j] = cubic_tap(row, wx);
      end
      plane[k] = cubic_tap(col, wy);
    end
    v = cubic_tap(plane, wz);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    r.value     = v[23:0];
    r.is_inside = (v < 0);
    return r;
  endfunction

  function automatic beat_t write_beat(input int x, input int y, input int z,
                                       input logic [15:0] val);
    beat_t b;
    b.kind = tlss_pkg::KIND_WRITE;
    b.cx = tlss_pkg::CELL_W'(x);
    b.cy = tlss_pkg::CELL_W'(y);
    b.cz = tlss_pkg::CELL_W'(z);
    b.sample = val;
    b.px = tlss_pkg::POINT_W'($urandom);
    b.py = tlss_pkg::POINT_W'($urandom);
    b.pz = tlss_pkg::POINT_W'($urandom);
    return b;
  endfunction

  function automatic beat_t eval_beat(input logic [tlss_pkg::POINT_W-1:0] px,
                                      input logic [tlss_pkg::POINT_W-1:0] py,
                                      input logic [tlss_pkg::POINT_W-1:0] pz);
    beat_t b;
    b.kind = tlss_pkg::KIND_EVAL;
    b.cx = tlss_pkg::CELL_W'($urandom);
    b.cy = tlss_pkg::CELL_W'($urandom);
    b.cz = tlss_pkg::CELL_W'($urandom);
    b.sample = tlss_pkg::SAMPLE_W'($urandom);
    b.px = px; b.py = py; b.pz = pz;
    return b;
  endfunction

  // Integer part drawn from the loaded corner regions.
  function automatic logic [tlss_pkg::POINT_W-1:0] corner_coord();
    int ints[5] = '{0, 1, 29, 30, 31};
    return {ints[$urandom_range(0, 4)][tlss_pkg::INT_BITS-1:0],
            tlss_pkg::FRAC_BITS'($urandom)};
  endfunction

  // Idling is off for a long stretch in the middle of the run.
  function automatic bit idle_now();
    if (cycle_count > 20000 && cycle_count < 60000) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: presents pending beats and updates the grid model on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (beat_on_bus.kind == tlss_pkg::KIND_WRITE) begin
          grid_model[(beat_on_bus.cz * DIM + beat_on_bus.cy) * DIM + beat_on_bus.cx] =
            beat_on_bus.sample;
        end else begin
          expected_fields.push_back(interpolate_field(beat_on_bus));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && !idle_now()) begin
          beat_on_bus = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= beat_on_bus.kind;
          s_axis_tdata  <= {4'b0, beat_on_bus.pz, beat_on_bus.py, beat_on_bus.px,
                            beat_on_bus.sample, beat_on_bus.cz, beat_on_bus.cy,
                            beat_on_bus.cx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    field_t exp_f;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_now();
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t unexpected beat: expected none, actual value %h inside %b",
                   $time, m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          exp_f = expected_fields.pop_front();
          if (m_axis_tdata !== exp_f.value) begin
            $display("%0t field_value mismatch: expected %h, actual %h",
                     $time, exp_f.value, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tuser !== exp_f.is_inside) begin
            $display("%0t is_inside mismatch: expected %b, actual %b",
                     $time, exp_f.is_inside, m_axis_tuser);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int x, y, z, n, wait_cycles;
    logic [tlss_pkg::POINT_W-1:0] px, py, pz;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Load the eight 4x4x4 corner regions (indices 0..3 and 28..31 per axis).
    for (z = 0; z < DIM; z++)
      for (y = 0; y < DIM; y++)
        for (x = 0; x < DIM; x++)
          if ((x < 4 || x > 27) && (y < 4 || y > 27) && (z < 4 || z > 27)) begin
            pending_beats.push_back(write_beat(x, y, z, 16'($urandom)));
            cell_loaded[(z * DIM + y) * DIM + x] = 1'b1;
          end

    // Directed: grid edges, zero and full fractions, half fractions.
    pending_beats.push_back(eval_beat(15'd0, 15'd0, 15'd0));
    pending_beats.push_back(eval_beat(15'h7fff, 15'h7fff, 15'h7fff));
    pending_beats.push_back(eval_beat(15'h0200, 15'h0600, 15'h7a00));
    pending_beats.push_back(eval_beat(15'h03ff, 15'h7c00, 15'h0001));
    pending_beats.push_back(eval_beat(15'h7800, 15'h0400, 15'h7fff));

    // Directed: origin neighborhood at the most negative, then most positive sample.
    for (n = 0; n < 2; n++) begin
      for (z = 0; z < 3; z++)
        for (y = 0; y < 3; y++)
          for (x = 0; x < 3; x++)
            pending_beats.push_back(write_beat(x, y, z, n ? 16'h7fff : 16'h8000));
      pending_beats.push_back(eval_beat(15'h0000, 15'h0000, 15'h0000));
      pending_beats.push_back(eval_beat(15'h0200, 15'h0100, 15'h03ff));
    end

    // Random: writes anywhere, evaluations only over loaded neighborhoods.
    for (n = 0; n < 1400; n++) begin
      if ($urandom_range(0, 99) < 45) begin
        if ($urandom_range(0, 3) == 0) begin
          x = $urandom_range(0, DIM - 1);
          y = $urandom_range(0, DIM - 1);
          z = $urandom_range(0, DIM - 1);
        end else begin
          x = corner_coord() >> tlss_pkg::FRAC_BITS;
          y = corner_coord() >> tlss_pkg::FRAC_BITS;
          z = corner_coord() >> tlss_pkg::FRAC_BITS;
        end
        pending_beats.push_back(write_beat(x, y, z, 16'($urandom)));
        cell_loaded[(z * DIM + y) * DIM + x] = 1'b1;
      end else begin
        px = tlss_pkg::POINT_W'($urandom);
        py = tlss_pkg::POINT_W'($urandom);
        pz = tlss_pkg::POINT_W'($urandom);
        if (!neighbors_loaded(px, py, pz)) begin
          px = corner_coord(); py = corner_coord(); pz = corner_coord();
        end
        pending_beats.push_back(eval_beat(px, py, pz));
      end
    end

    // Drain, then let the pipeline settle.
    while (pending_beats.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
    wait_cycles = 200;
    repeat (wait_cycles) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> tricubic_level_set_sampler_unit.f
rtl/core/tlss_pkg.sv
rtl/core/tlss_front.sv
rtl/core/tlss_back.sv
rtl/core/tricubic_level_set_sampler_unit.sv
tb/tricubic_level_set_sampler_unit_tb.sv
